### sv/trk_pkg.sv
// Shared types, constants and box helpers for the tile dirty region tracker.
package trk_pkg;

  localparam int TILE_SHIFT = 4;
  localparam int GRID_COLS  = 16;
  localparam int GRID_ROWS  = 16;
  localparam int LIST_DEPTH = 8;
  localparam int MAX_OUT    = 8;

  localparam logic [2:0] K_MARK_RECT  = 3'd0;
  localparam logic [2:0] K_MARK_PIXEL = 3'd1;
  localparam logic [2:0] K_MARK_ALL   = 3'd2;
  localparam logic [2:0] K_CLEAR_ALL  = 3'd3;
  localparam logic [2:0] K_QUERY      = 3'd4;
  localparam logic [2:0] K_READ_LIST  = 3'd5;
  localparam logic [2:0] K_TIGHT_BOX  = 3'd6;

  localparam logic [1:0] CFG_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_ENABLE    = 2'd3;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
    logic [8:0] w;
    logic [8:0] h;
  } box_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [3:0]  max_count;
  } item_t;

  typedef struct packed {
    logic [8:0] scrw;
    logic [8:0] scrh;
    logic [4:0] gw;
    logic [4:0] gh;
    logic [6:0] thr;
    logic       en;
  } cfg_t;

  typedef struct packed {
    box_t       b;
    logic       v;
    logic       hit;
    logic [8:0] tiles;
    logic [6:0] pct;
    logic       full;
    logic       last;
  } res_t;

  function automatic logic box_overlap(input box_t a, input box_t b);
    logic [9:0] ax2, ay2, bx2, by2;
    ax2 = {1'b0, a.x} + {1'b0, a.w};
    ay2 = {1'b0, a.y} + {1'b0, a.h};
    bx2 = {1'b0, b.x} + {1'b0, b.w};
    by2 = {1'b0, b.y} + {1'b0, b.h};
    if (a.w == '0 || a.h == '0 || b.w == '0 || b.h == '0) return 1'b0;
    return ({1'b0, a.x} < bx2) && ({1'b0, b.x} < ax2) &&
           ({1'b0, a.y} < by2) && ({1'b0, b.y} < ay2);
  endfunction

  function automatic box_t box_union(input box_t a, input box_t b);
    logic [9:0] ax2, ay2, bx2, by2, x2, y2;
    box_t r;
    ax2 = {1'b0, a.x} + {1'b0, a.w};
    ay2 = {1'b0, a.y} + {1'b0, a.h};
    bx2 = {1'b0, b.x} + {1'b0, b.w};
    by2 = {1'b0, b.y} + {1'b0, b.h};
    x2 = (ax2 > bx2) ? ax2 : bx2;
    y2 = (ay2 > by2) ? ay2 : by2;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = 9'(x2 - {1'b0, r.x});
    r.h = 9'(y2 - {1'b0, r.y});
    return r;
  endfunction

  // bit t set when lo <= t <= hi and t < lim
  function automatic logic [GRID_COLS-1:0] range_mask(input logic signed [17:0] lo,
                                                      input logic signed [17:0] hi,
                                                      input logic [4:0] lim);
    logic [GRID_COLS-1:0] m;
    logic signed [17:0] ts;
    m = '0;
    for (int t = 0; t < GRID_COLS; t++) begin
      ts = $signed(18'(t));
      m[t] = (ts >= lo) && (ts <= hi) && (5'(t) < lim);
    end
    return m;
  endfunction

  function automatic logic [4:0] popcount16(input logic [GRID_COLS-1:0] v);
    logic [4:0] c;
    c = '0;
    for (int t = 0; t < GRID_COLS; t++) c = c + 5'(v[t]);
    return c;
  endfunction

endpackage

### sv/trk_div.sv
// Restoring divider, one quotient bit per cycle, for the dirty percentage.
module trk_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [14:0] num,
  input  logic [8:0]  den,
  output logic        done,
  output logic [14:0] quo
);
  logic        busy;
  logic [3:0]  cnt;
  logic [8:0]  rem;
  logic [14:0] nsh;
  logic [9:0]  trial;
  logic        ge;

  assign trial = {rem, nsh[14]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nsh  <= num;
      end else if (busy) begin
        rem <= ge ? 9'(trial - {1'b0, den}) : trial[8:0];
        quo <= {quo[13:0], ge};
        nsh <= {nsh[13:0], 1'b0};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd14) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/trk_ctl.sv
// Sequencer: tile bitmap, rectangle list, and per-item row and list walks.
module trk_ctl (
  input  logic          clk,
  input  logic          rst,
  input  trk_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  trk_pkg::item_t item,
  input  logic          slot_free,
  output logic          emit,
  output trk_pkg::res_t res_o
);
  import trk_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SET    = 4'd1;
  localparam logic [3:0] S_LIST   = 4'd2;
  localparam logic [3:0] S_MERGE  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_DIVW   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_TBOX   = 4'd7;
  localparam logic [3:0] S_LISTRD = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state;

  logic [GRID_COLS-1:0]  rows [GRID_ROWS];
  logic [8:0]            total;
  box_t                  bbox;
  box_t                  ent [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] vld;
  logic [3:0]            used;

  logic [2:0]           kind;
  logic [3:0]           maxc;
  box_t                 cbox;
  logic [GRID_COLS-1:0] colmask;
  logic [GRID_ROWS-1:0] rowmask;
  logic                 qgate, upd;
  logic [3:0]           r;
  logic [3:0]           li, n;
  box_t                 acc;
  logic [GRID_COLS-1:0] colacc;
  logic                 anyrow;
  logic [3:0]           miny, maxy;
  logic [6:0]           pct;
  logic                 full;
  box_t                 res;
  logic                 resv, reshit;

  // divider hookup
  logic        div_start, div_done;
  logic [14:0] div_num, div_quo;
  logic [8:0]  div_den;
  logic [9:0]  grid_tiles;
  logic [6:0]  pct_n;
  logic        full_n;

  trk_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign grid_tiles = cfg.gw * cfg.gh;
  assign div_den    = grid_tiles[8:0];
  assign div_num    = 15'({total, 6'b0}) + 15'({total, 5'b0}) + 15'({total, 2'b0});
  assign div_start  = (state == S_DIV);
  assign pct_n      = (div_quo > 15'd100) ? 7'd100 : div_quo[6:0];
  assign full_n     = pct_n >= cfg.thr;

  // item decode at accept
  logic signed [17:0] ix, iy, iw, ih, scw, sch, x2, y2, cx, cy, x2c, y2c;
  logic signed [17:0] qrx, qry, bx, by, bx2, by2;
  logic               rect_ok, q_ok;
  logic [GRID_COLS-1:0] m_col, q_col, g_col;
  logic [GRID_ROWS-1:0] m_row, q_row, g_row;
  box_t                 cbox_n, fullbox;

  always_comb begin
    ix  = {{2{item.x[15]}}, item.x};
    iy  = {{2{item.y[15]}}, item.y};
    iw  = (item.kind == K_MARK_PIXEL) ? 18'sd1 : $signed({2'b0, item.w});
    ih  = (item.kind == K_MARK_PIXEL) ? 18'sd1 : $signed({2'b0, item.h});
    scw = $signed({9'b0, cfg.scrw});
    sch = $signed({9'b0, cfg.scrh});
    x2  = ix + iw;
    y2  = iy + ih;
    cx  = ix[17] ? 18'sd0 : ix;
    cy  = iy[17] ? 18'sd0 : iy;
    x2c = (x2 > scw) ? scw : x2;
    y2c = (y2 > sch) ? sch : y2;
    rect_ok = (iw != 18'sd0) && (ih != 18'sd0) && (x2c > cx) && (y2c > cy);
    cbox_n.x = cx[8:0];
    cbox_n.y = cy[8:0];
    cbox_n.w = 9'(x2c - cx);
    cbox_n.h = 9'(y2c - cy);
    m_col = range_mask(cx >>> TILE_SHIFT, (x2c - 18'sd1) >>> TILE_SHIFT, cfg.gw);
    m_row = range_mask(cy >>> TILE_SHIFT, (y2c - 18'sd1) >>> TILE_SHIFT, cfg.gh);
    // query window
    qrx = x2 - 18'sd1;
    qry = y2 - 18'sd1;
    if (qrx > scw - 18'sd1) qrx = scw - 18'sd1;
    if (qry > sch - 18'sd1) qry = sch - 18'sd1;
    q_col = range_mask(cx >>> TILE_SHIFT, qrx >>> TILE_SHIFT, cfg.gw);
    q_row = range_mask(cy >>> TILE_SHIFT, qry >>> TILE_SHIFT, cfg.gh);
    bx  = $signed({9'b0, bbox.x});
    by  = $signed({9'b0, bbox.y});
    bx2 = $signed({8'b0, {1'b0, bbox.x} + {1'b0, bbox.w}});
    by2 = $signed({8'b0, {1'b0, bbox.y} + {1'b0, bbox.h}});
    q_ok = (total != '0) && (iw != 18'sd0) && (ih != 18'sd0) &&
           (bbox.w != '0) && (bbox.h != '0) &&
           (bx < x2) && (ix < bx2) && (by < y2) && (iy < by2);
    g_col = range_mask(18'sd0, 18'sd15, cfg.gw);
    g_row = range_mask(18'sd0, 18'sd15, cfg.gh);
    fullbox.x = '0;
    fullbox.y = '0;
    fullbox.w = cfg.scrw;
    fullbox.h = cfg.scrh;
  end

  // tight box from the scan
  logic [3:0] lo, hi;
  logic [8:0] mnx, mny, mxx, mxy, mxx_r, mxy_r;
  always_comb begin
    lo = '0;
    hi = '0;
    for (int t = GRID_COLS - 1; t >= 0; t--) if (colacc[t]) lo = 4'(t);
    for (int t = 0; t < GRID_COLS; t++) if (colacc[t]) hi = 4'(t);
    mnx   = {1'b0, lo, 4'b0};
    mny   = {1'b0, miny, 4'b0};
    mxx_r = {5'({1'b0, hi} + 5'd1), 4'b0};
    mxy_r = {5'({1'b0, maxy} + 5'd1), 4'b0};
    mxx   = (mxx_r > cfg.scrw) ? cfg.scrw : mxx_r;
    mxy   = (mxy_r > cfg.scrh) ? cfg.scrh : mxy_r;
  end

  logic [GRID_COLS-1:0] row_cur, new_bits, scan_bits;
  box_t                 acc_n;
  logic                 rd_last;
  assign row_cur   = rows[r];
  assign new_bits  = colmask & ~row_cur;
  assign scan_bits = row_cur & colmask;
  assign acc_n     = vld[li[2:0]] ? box_union(acc, ent[li[2:0]]) : acc;
  assign rd_last   = (n + 4'd1 == maxc) || (li + 4'd1 == used);

  assign in_ready = (state == S_IDLE);
  assign emit = slot_free && (state == S_EMIT || state == S_LISTRD);

  always_comb begin
    res_o.tiles = total;
    res_o.pct   = pct;
    res_o.full  = full;
    if (state == S_LISTRD) begin
      res_o.b    = ent[li[2:0]];
      res_o.v    = 1'b1;
      res_o.hit  = 1'b0;
      res_o.last = rd_last;
    end else begin
      res_o.b    = res;
      res_o.v    = resv;
      res_o.hit  = reshit;
      res_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      bbox  <= '0;
      vld   <= '0;
      used  <= '0;
      for (int i = 0; i < GRID_ROWS; i++) rows[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind   <= item.kind;
            maxc   <= (item.max_count > 4'(MAX_OUT)) ? 4'(MAX_OUT) : item.max_count;
            cbox   <= cbox_n;
            qgate  <= q_ok;
            reshit <= 1'b0;
            res    <= '0;
            resv   <= 1'b0;
            r      <= '0;
            li     <= '0;
            upd    <= (item.kind == K_MARK_RECT);
            colmask <= m_col;
            rowmask <= m_row;
            state  <= S_DIV;
            case (item.kind) inside
              K_MARK_RECT, K_MARK_PIXEL: begin
                if (cfg.en && rect_ok) begin
                  bbox  <= (bbox.w == '0 || bbox.h == '0) ? cbox_n : box_union(bbox, cbox_n);
                  state <= S_SET;
                end
              end
              K_MARK_ALL: begin
                if (cfg.en) begin
                  for (int i = 0; i < GRID_ROWS; i++) rows[i] <= g_row[i] ? g_col : '0;
                  total  <= grid_tiles[8:0];
                  bbox   <= fullbox;
                  ent[0] <= fullbox;
                  vld    <= LIST_DEPTH'(1);
                  used   <= 4'd1;
                end
              end
              K_CLEAR_ALL: begin
                for (int i = 0; i < GRID_ROWS; i++) rows[i] <= '0;
                total <= '0;
                bbox  <= '0;
                vld   <= '0;
                used  <= '0;
              end
              K_QUERY: begin
                colmask <= q_col;
                rowmask <= q_row;
              end
              K_TIGHT_BOX: begin
                colmask <= g_col;
                rowmask <= g_row;
              end
              default: ;
            endcase
          end
        end
        S_SET: begin
          if (rowmask[r]) begin
            rows[r] <= row_cur | colmask;
            total   <= total + 9'(popcount16(new_bits));
          end
          r <= r + 4'd1;
          if (r == 4'(GRID_ROWS - 1)) state <= upd ? S_LIST : S_DIV;
        end
        S_LIST: begin
          if (li < used) begin
            if (vld[li[2:0]] && box_overlap(ent[li[2:0]], cbox)) begin
              ent[li[2:0]] <= box_union(ent[li[2:0]], cbox);
              state <= S_DIV;
            end else begin
              li <= li + 4'd1;
            end
          end else if (used < 4'(LIST_DEPTH)) begin
            ent[used[2:0]] <= cbox;
            vld[used[2:0]] <= 1'b1;
            used  <= used + 4'd1;
            state <= S_DIV;
          end else begin
            acc   <= cbox;
            li    <= '0;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (li == 4'(LIST_DEPTH - 1)) begin
            ent[0] <= acc_n;
            vld    <= LIST_DEPTH'(1);
            used   <= 4'd1;
            state  <= S_DIV;
          end else begin
            vld[li[2:0]] <= 1'b0;
            acc <= acc_n;
            li  <= li + 4'd1;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            pct   <= pct_n;
            full  <= full_n;
            r     <= '0;
            li    <= '0;
            n     <= '0;
            colacc <= '0;
            anyrow <= 1'b0;
            state <= S_EMIT;
            case (kind)
              K_QUERY: if (qgate) state <= S_SCAN;
              K_READ_LIST: begin
                if (maxc == '0) begin
                  resv <= 1'b0;
                end else if (full_n) begin
                  res <= fullbox;
                  resv <= 1'b1;
                end else if (used == '0) begin
                  if (total != '0) begin
                    res  <= bbox;
                    resv <= 1'b1;
                  end
                end else begin
                  state <= S_LISTRD;
                end
              end
              K_TIGHT_BOX: begin
                if (total != '0) begin
                  if (full_n) begin
                    res  <= fullbox;
                    resv <= 1'b1;
                  end else begin
                    state <= S_SCAN;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (rowmask[r] && (scan_bits != '0)) begin
            reshit <= (kind == K_QUERY);
            colacc <= colacc | scan_bits;
            if (!anyrow) miny <= r;
            maxy   <= r;
            anyrow <= 1'b1;
          end
          r <= r + 4'd1;
          if (r == 4'(GRID_ROWS - 1)) state <= (kind == K_QUERY) ? S_EMIT : S_TBOX;
        end
        S_TBOX: begin
          if (anyrow && (mxx > mnx) && (mxy > mny)) begin
            res.x <= mnx;
            res.y <= mny;
            res.w <= mxx - mnx;
            res.h <= mxy - mny;
            resv  <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_LISTRD: begin
          if (slot_free) begin
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              li <= li + 4'd1;
              n  <= n + 4'd1;
            end
          end
        end
        S_EMIT: if (slot_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/tile_dirty_region_tracker.sv
// Top level: config registers, stream ports and result register around the sequencer.
// Work per item: a rectangle or pixel mark first walks the 16 tile rows and a rectangle mark
// then walks, and when full merges, the rectangle list; every item then runs the divider,
// and a query or tight box may then scan the 16 tile rows.
// One item at a time: s_tready is high only while idle, so the next item waits for the
// whole walk, every list word and any output stall.
// Reset (rst, synchronous, active high) clears tile map, counts, box and list, and loads
// the screen size 240 x 135, threshold 50 and tracking enabled.
module tile_dirty_region_tracker (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // rect_x[15:0], rect_y[31:16], rect_w[47:32],
                                // rect_h[63:48], max_count[67:64], zero pad
  input  logic [2:0]  s_tuser,  // kind
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // region_x[7:0], region_y[15:8], region_w[24:16],
                                // region_h[33:25], region_valid[34], hit[35],
                                // dirty_tiles[44:36], dirty_percent[51:45],
                                // full_refresh[52], zero pad
  output logic        m_tlast
);
  import trk_pkg::*;

  logic [8:0] reg_w, reg_h;
  logic [6:0] reg_thr;
  logic       reg_en;
  cfg_t       cfg;
  item_t      item;
  logic       emit, slot_free;
  res_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w   <= 9'd240;
      reg_h   <= 9'd135;
      reg_thr <= 7'd50;
      reg_en  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:     reg_w   <= cfg_data;
        CFG_HEIGHT:    reg_h   <= cfg_data;
        CFG_THRESHOLD: reg_thr <= cfg_data[6:0];
        CFG_ENABLE:    reg_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..256, threshold to 100; grid is ceil(size/16)
  logic [9:0] w_sum, h_sum;
  always_comb begin
    cfg.scrw = (reg_w == '0) ? 9'd1 : (reg_w > 9'd256) ? 9'd256 : reg_w;
    cfg.scrh = (reg_h == '0) ? 9'd1 : (reg_h > 9'd256) ? 9'd256 : reg_h;
    w_sum    = {1'b0, cfg.scrw} + 10'd15;
    h_sum    = {1'b0, cfg.scrh} + 10'd15;
    cfg.gw   = w_sum[8:TILE_SHIFT];
    cfg.gh   = h_sum[8:TILE_SHIFT];
    cfg.thr  = (reg_thr > 7'd100) ? 7'd100 : reg_thr;
    cfg.en   = reg_en;
  end

  assign item.kind      = s_tuser;
  assign item.x         = s_tdata[15:0];
  assign item.y         = s_tdata[31:16];
  assign item.w         = s_tdata[47:32];
  assign item.h         = s_tdata[63:48];
  assign item.max_count = s_tdata[67:64];

  // result register frees the sequencer as soon as the word is taken
  assign slot_free = !m_tvalid || m_tready;

  trk_ctl u_ctl (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready), .item(item),
    .slot_free(slot_free), .emit(emit), .res_o(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {3'b0, res.full, res.pct, res.tiles, res.hit, res.v,
                  res.b.h, res.b.w, res.b.y[7:0], res.b.x[7:0]};
      m_tlast <= res.last;
    end
  end
endmodule

### sv/trk_chk.sv
// Port-level checks for the tracker, bound to the top level.
module trk_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("took a second word while busy");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[34] |-> m_tdata[33:0] == 34'd0)
    else $error("invalid region carries nonzero fields");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35] |-> m_tlast && !m_tdata[34])
    else $error("hit on a non-query word");

  a_pct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[51:45] <= 7'd100)
    else $error("percentage above 100");
endmodule

bind tile_dirty_region_tracker trk_chk u_chk (.*);
